// ===== sv/dfc_pkg.sv =====
// Package for the download frame checker: verdict codes, register indexes,
// reset values and the CRC-16/Modbus byte update. No dependencies.
package dfc_pkg;

   localparam int unsigned MaxFrameBytesDefault = 2048;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned CountWidth = 12;
   localparam int unsigned PayloadWidth = 11;

   localparam logic [7:0]  StationReset = 8'd1;
   localparam logic [31:0] BaseReset = 32'd0;
   localparam logic [15:0] StrideReset = 16'd1400;
   localparam logic [15:0] FinalTotalReset = 16'd188;
   localparam logic [15:0] FinalLimitReset = 16'd344;
   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'hA001;
   localparam logic [15:0] FrameNumberEnd = 16'hFFFF;
   localparam logic [12:0] MinFrameBytes = 13'd7;

   typedef enum logic [2:0] {
      V_START    = 3'd0,
      V_WRITTEN  = 3'd1,
      V_CRC      = 3'd2,
      V_STATION  = 3'd3,
      V_LENGTH   = 3'd4,
      V_OVERFLOW = 3'd5,
      V_END      = 3'd6,
      V_BADSIZE  = 3'd7
   } verdict_type;

   typedef enum logic [CsrAddrWidth-1:0] {
      REG_STATION     = 3'd0,
      REG_BASE        = 3'd1,
      REG_STRIDE      = 3'd2,
      REG_FINAL_TOTAL = 3'd3,
      REG_FINAL_LIMIT = 3'd4
   } csr_index_type;

   // Reflected CRC-16 update over one byte, one bit per step.
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/dfc_if.sv =====
// Channel interfaces of the download frame checker: input bytes, verdicts
// and register writes. Depends on dfc_pkg.
interface dfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_end;
   modport source (output valid, data_byte, frame_end, input ready);
   modport sink (input valid, data_byte, frame_end, output ready);
endinterface

interface dfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  verdict;
   logic        erase_request;
   logic        write_request;
   logic [31:0] write_address;
   logic [10:0] payload_length;
   logic        session_closed;
   modport source (output valid, verdict, erase_request, write_request, write_address,
                   payload_length, session_closed, input ready);
   modport sink (input valid, verdict, erase_request, write_request, write_address,
                 payload_length, session_closed, output ready);
endinterface

interface dfc_csr_if;
   import dfc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CsrAddrWidth-1:0] addr;
   logic [CsrDataWidth-1:0] data;
   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

// ===== sv/download_frame_checker.sv =====
// Top level of the download frame checker: frame state, CRC, verdict logic
// and the result register. Depends on dfc_pkg and the interfaces in dfc_if.
// Throughput is one byte per cycle unless a register write or an untaken verdict
// holds input; a verdict is valid the cycle after its last word, in one register.
// The address product is registered each cycle from the stored frame number.
// Input ready drops for one cycle after each register write.
// Synchronous reset loads the register defaults and clears the frame state.
module download_frame_checker #(
   parameter int unsigned MAX_FRAME_BYTES = dfc_pkg::MaxFrameBytesDefault
) (
   input logic       clock,
   input logic       reset,
   dfc_req_if.sink   req,
   dfc_rsp_if.source rsp,
   dfc_csr_if.sink   csr
);
   import dfc_pkg::*;

   localparam logic [12:0] MaxBytes = 13'(MAX_FRAME_BYTES);

   logic [7:0]  station_ff;
   logic [31:0] base_ff;
   logic [15:0] stride_ff, final_total_ff, final_limit_ff;
   logic        cfg_hold_ff;

   logic [15:0] crc_ff, crc_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [7:0]  held0_ff, held0_in, held1_ff, held1_in;
   logic [7:0]  hstation_ff, hstation_in;
   logic [15:0] hnumber_ff, hnumber_in, htotal_ff, htotal_in;
   logic        too_long_ff, too_long_in;
   logic [31:0] prod_ff, prod_in;

   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type verdict_ff, verdict_in;
   logic [31:0] addr_ff, addr_in;
   logic [PayloadWidth-1:0] plen_ff, plen_in;

   logic        req_acc, csr_acc, last;
   logic [12:0] length, payload;
   logic [15:0] crc_chk, number_m1;

   assign csr.ready = 1'b1;
   assign csr_acc = csr.valid && csr.ready;
   assign req.ready = (!rsp_valid_ff || rsp.ready) && !cfg_hold_ff;
   assign req_acc = req.valid && req.ready;
   assign last = req.frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff <= StationReset;
         base_ff <= BaseReset;
         stride_ff <= StrideReset;
         final_total_ff <= FinalTotalReset;
         final_limit_ff <= FinalLimitReset;
         cfg_hold_ff <= 1'b0;
      end else begin
         cfg_hold_ff <= csr_acc;
         if (csr_acc) begin
            unique case (csr.addr)
               REG_STATION:     station_ff <= csr.data[7:0];
               REG_BASE:        base_ff <= csr.data;
               REG_STRIDE:      stride_ff <= csr.data[15:0];
               REG_FINAL_TOTAL: final_total_ff <= csr.data[15:0];
               REG_FINAL_LIMIT: final_limit_ff <= csr.data[15:0];
               default: ;
            endcase
         end
      end
   end

   assign number_m1 = hnumber_ff - 16'd1;
   assign prod_in = {16'd0, number_m1} * {16'd0, stride_ff};
   assign length = {1'b0, count_ff} + 13'd1;
   assign payload = (length >= MinFrameBytes) ? length - MinFrameBytes : 13'd0;
   assign crc_chk = (count_ff >= CountWidth'(2)) ? crc_update(crc_ff, held1_ff) : crc_ff;

   always_comb begin
      crc_in = crc_ff;
      count_in = count_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      hstation_in = hstation_ff;
      hnumber_in = hnumber_ff;
      htotal_in = htotal_ff;
      too_long_in = too_long_ff;
      if (req_acc) begin
         if (last) begin
            crc_in = CrcInit;
            count_in = '0;
            held0_in = '0;
            held1_in = '0;
            hstation_in = '0;
            hnumber_in = '0;
            htotal_in = '0;
            too_long_in = 1'b0;
         end else begin
            crc_in = crc_chk;
            held1_in = held0_ff;
            held0_in = req.data_byte;
            if (count_ff != '1) begin
               count_in = count_ff + CountWidth'(1);
            end
            if (length > MaxBytes) begin
               too_long_in = 1'b1;
            end
            case (count_ff)
               CountWidth'(0): hstation_in = req.data_byte;
               CountWidth'(1): hnumber_in = {req.data_byte, hnumber_ff[7:0]};
               CountWidth'(2): hnumber_in = {hnumber_ff[15:8], req.data_byte};
               CountWidth'(3): htotal_in = {req.data_byte, htotal_ff[7:0]};
               CountWidth'(4): htotal_in = {htotal_ff[15:8], req.data_byte};
               default: ;
            endcase
         end
      end
   end

   // Headers are complete by the last word of any frame that passes the size test.
   always_comb begin
      addr_in = '0;
      plen_in = '0;
      if (too_long_ff || length > MaxBytes || length < MinFrameBytes) begin
         verdict_in = V_BADSIZE;
      end else if (crc_chk[7:0] != held0_ff || crc_chk[15:8] != req.data_byte) begin
         verdict_in = V_CRC;
      end else if (hstation_ff != station_ff) begin
         verdict_in = V_STATION;
      end else if (hnumber_ff == 16'd0) begin
         verdict_in = V_START;
      end else if (hnumber_ff == FrameNumberEnd) begin
         verdict_in = V_END;
      end else if (htotal_ff == final_total_ff && {3'd0, payload} > final_limit_ff) begin
         verdict_in = V_OVERFLOW;
      end else if (hnumber_ff == {3'd0, payload}) begin
         verdict_in = V_LENGTH;
      end else begin
         verdict_in = V_WRITTEN;
         addr_in = base_ff + prod_ff;
         plen_in = payload[PayloadWidth-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (req_acc && last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CrcInit;
         count_ff <= '0;
         held0_ff <= '0;
         held1_ff <= '0;
         hstation_ff <= '0;
         hnumber_ff <= '0;
         htotal_ff <= '0;
         too_long_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff <= crc_in;
         count_ff <= count_in;
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         hstation_ff <= hstation_in;
         hnumber_ff <= hnumber_in;
         htotal_ff <= htotal_in;
         too_long_ff <= too_long_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (req_acc && last) begin
         verdict_ff <= verdict_in;
         addr_ff <= addr_in;
         plen_ff <= plen_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.verdict = verdict_ff;
   assign rsp.erase_request = (verdict_ff == V_START);
   assign rsp.write_request = (verdict_ff == V_WRITTEN);
   assign rsp.write_address = addr_ff;
   assign rsp.payload_length = plen_ff;
   assign rsp.session_closed = (verdict_ff == V_END) || (verdict_ff == V_BADSIZE);

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      req_acc && last |=> count_ff == '0 && crc_ff == CrcInit && !too_long_ff)
      else $error("frame state not cleared after the last word");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_acc && last |=> rsp.valid)
      else $error("no verdict after the last word");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |=> !rsp.valid || $past(req_acc && last))
      else $error("verdict appeared without a last word");

   a_cfg_hold: assert property (@(posedge clock) disable iff (reset)
      csr_acc |=> !req.ready)
      else $error("input accepted right after a register write");

   a_write_fields: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && verdict_ff != V_WRITTEN |-> addr_ff == '0 && plen_ff == '0)
      else $error("address or length set without a write");

endmodule

// ===== tb/download_frame_checker_tb.sv =====
`timescale 1ns / 1ps
// Testbench for download_frame_checker: directed and random download frames, each verdict word
// checked against a predictor kept inside this file. Depends on dfc_pkg and the dfc_if interfaces.
module download_frame_checker_tb;
   import dfc_pkg::*;

   localparam int FrameLimit = MaxFrameBytesDefault;
   localparam int CountCeiling = (1 << CountWidth) - 1;
   localparam int RandomWords = 1080;
   localparam logic [1:0] PresetNone = 2'd0;
   localparam logic [1:0] PresetHigh = 2'd1;
   localparam logic [1:0] PresetLow = 2'd2;
   localparam logic [1:0] PresetMid = 2'd3;
   localparam logic [15:0] MidLimit = 16'd20;

   typedef struct packed {
      verdict_type verdict;
      logic        erase_request;
      logic        write_request;
      logic [31:0] write_address;
      logic [10:0] payload_length;
      logic        session_closed;
   } frame_verdict_type;

   typedef struct packed {
      logic [1:0]  preset;
      logic [12:0] raw_len;
      logic [7:0]  station;
      logic [15:0] number;
      logic [15:0] total;
      logic [12:0] payload;
      logic        crc_good;
      logic        typed;
      verdict_type want;
   } frame_plan_type;

   logic clock;
   logic reset;

   dfc_req_if req_if ();
   dfc_rsp_if rsp_if ();
   dfc_csr_if csr_if ();

   download_frame_checker dut (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if),
      .csr(csr_if)
   );

   logic [15:0] crc_lut [256];

   logic [7:0]  cfg_station = StationReset;
   logic [31:0] cfg_base = BaseReset;
   logic [15:0] cfg_stride = StrideReset;
   logic [15:0] cfg_final_total = FinalTotalReset;
   logic [15:0] cfg_final_limit = FinalLimitReset;

   logic [15:0] crc_run = CrcInit;
   int          frame_pos = 0;
   logic [7:0]  recent [2] = '{8'h00, 8'h00};
   logic [7:0]  hdr_station = 8'h00;
   logic [15:0] hdr_number = 16'h0000;
   logic [15:0] hdr_total = 16'h0000;
   logic        oversize = 1'b0;

   frame_verdict_type pending_verdicts [$];
   logic [7:0]        frame_bytes [$];
   logic [2:0]        last_seen_verdict;
   int                verdict_tally [8];
   int                mismatches = 0;
   int                verdicts_checked = 0;
   int                words_sent = 0;
   int                frames_sent = 0;
   int                burst_left = 0;
   int                stall_mode = 0;
   int                stall_phase = 0;

   frame_plan_type directed_plan [0:21] = '{
      '{PresetNone, 1, 0, 0, 0, 0, 0, 1, V_BADSIZE},
      '{PresetNone, 6, 0, 0, 0, 0, 0, 1, V_BADSIZE},
      '{PresetNone, 0, 1, 1, 5, 0, 1, 1, V_WRITTEN},
      '{PresetNone, 0, 1, 2, 5, 3, 0, 1, V_CRC},
      '{PresetNone, 0, 2, 2, 5, 3, 1, 1, V_STATION},
      '{PresetNone, 0, 1, 0, 5, 3, 1, 1, V_START},
      '{PresetNone, 0, 1, 16'hFFFF, 5, 3, 1, 1, V_END},
      '{PresetMid, 0, 1, 3, 188, 21, 1, 1, V_OVERFLOW},
      '{PresetNone, 0, 1, 3, 188, 20, 1, 1, V_WRITTEN},
      '{PresetNone, 0, 1, 21, 188, 21, 1, 1, V_OVERFLOW},
      '{PresetNone, 0, 1, 5, 9, 5, 1, 1, V_LENGTH},
      '{PresetNone, 0, 1, 2, 9, 10, 1, 0, V_WRITTEN},
      '{PresetNone, 7, 0, 0, 0, 0, 0, 0, V_WRITTEN},
      '{PresetNone, 0, 1, 16'hFFFF, 5, 3, 0, 1, V_CRC},
      '{PresetNone, 0, 3, 0, 5, 0, 1, 1, V_STATION},
      '{PresetHigh, 0, 8'hFF, 16'hFFFE, 1, 2, 1, 0, V_WRITTEN},
      '{PresetNone, 0, 8'hFF, 1, 16'hFFFF, 1, 1, 1, V_OVERFLOW},
      '{PresetNone, 0, 8'hFF, 16'hFFFF, 16'hFFFF, 1, 1, 1, V_END},
      '{PresetNone, 0, 8'hFF, 8, 16'hFFFF, 0, 1, 1, V_WRITTEN},
      '{PresetNone, 0, 1, 8, 0, 0, 1, 1, V_STATION},
      '{PresetLow, 0, 0, 9, 0, 20, 1, 0, V_WRITTEN},
      '{PresetNone, 0, 0, 4, 0, 4, 1, 1, V_LENGTH}
   };

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      return (crc >> 8) ^ crc_lut[crc[7:0] ^ b];
   endfunction

   // Returns 1 when the byte closes a frame, with the verdict word in word.
   function automatic bit judge_byte(input logic [7:0] b, input logic last,
                                     output frame_verdict_type word);
      int len;
      int payload;
      verdict_type v;
      len = frame_pos + 1;
      word = '0;
      if (frame_pos >= 2) crc_run = crc_step(crc_run, recent[1]);
      case (frame_pos)
         0: hdr_station = b;
         1: hdr_number[15:8] = b;
         2: hdr_number[7:0] = b;
         3: hdr_total[15:8] = b;
         4: hdr_total[7:0] = b;
         default: ;
      endcase
      if (len > FrameLimit) oversize = 1'b1;
      if (!last) begin
         recent[1] = recent[0];
         recent[0] = b;
         if (frame_pos < CountCeiling) frame_pos++;
         return 1'b0;
      end
      payload = (len >= int'(MinFrameBytes)) ? len - int'(MinFrameBytes) : 0;
      if (oversize || len < int'(MinFrameBytes)) v = V_BADSIZE;
      else if (crc_run[7:0] != recent[0] || crc_run[15:8] != b) v = V_CRC;
      else if (hdr_station != cfg_station) v = V_STATION;
      else if (hdr_number == 16'h0000) v = V_START;
      else if (hdr_number == FrameNumberEnd) v = V_END;
      else if (hdr_total == cfg_final_total && payload > int'(cfg_final_limit)) v = V_OVERFLOW;
      else if (int'(hdr_number) == payload) v = V_LENGTH;
      else v = V_WRITTEN;
      word.verdict = v;
      word.erase_request = (v == V_START);
      word.write_request = (v == V_WRITTEN);
      word.session_closed = (v == V_END || v == V_BADSIZE);
      if (v == V_WRITTEN) begin
         word.write_address = cfg_base + (32'(hdr_number) - 32'd1) * 32'(cfg_stride);
         word.payload_length = 11'(payload);
      end
      crc_run = CrcInit;
      frame_pos = 0;
      recent[0] = 8'h00;
      recent[1] = 8'h00;
      hdr_station = 8'h00;
      hdr_number = 16'h0000;
      hdr_total = 16'h0000;
      oversize = 1'b0;
      return 1'b1;
   endfunction

   function automatic void build_frame(input int raw_len, input logic [7:0] station,
                                       input logic [15:0] number, input logic [15:0] total,
                                       input int payload, input bit crc_good);
      logic [15:0] crc;
      int spot;
      frame_bytes = {};
      if (raw_len != 0) begin
         repeat (raw_len) frame_bytes.push_back(8'($urandom));
         return;
      end
      frame_bytes.push_back(station);
      frame_bytes.push_back(number[15:8]);
      frame_bytes.push_back(number[7:0]);
      frame_bytes.push_back(total[15:8]);
      frame_bytes.push_back(total[7:0]);
      repeat (payload) frame_bytes.push_back(8'($urandom));
      crc = CrcInit;
      foreach (frame_bytes[i]) crc = crc_step(crc, frame_bytes[i]);
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
      if (!crc_good) begin
         spot = $urandom_range(0, frame_bytes.size() - 1);
         frame_bytes[spot] = frame_bytes[spot] ^ 8'($urandom_range(1, 255));
      end
   endfunction

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      mismatches++;
      $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
   endtask

   // Entered and left at a falling edge; valid stays high after the word is taken.
   task automatic drive_word(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.data_byte <= b;
      req_if.frame_end <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) drive_word(frame_bytes[i], i == frame_bytes.size() - 1);
      frames_sent++;
   endtask

   task automatic write_register(input logic [CsrAddrWidth-1:0] index,
                                 input logic [CsrDataWidth-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.addr <= index;
      csr_if.data <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] station, input logic [31:0] base,
                                 input logic [15:0] stride, input logic [15:0] total,
                                 input logic [15:0] limit);
      req_if.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_register(REG_STATION, {24'($urandom), station});
      write_register(REG_BASE, base);
      write_register(REG_STRIDE, {16'($urandom), stride});
      write_register(REG_FINAL_TOTAL, {16'($urandom), total});
      write_register(REG_FINAL_LIMIT, {16'($urandom), limit});
      write_register(REG_FINAL_LIMIT + 3'($urandom_range(1, 3)), $urandom);
      csr_if.valid <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      logic [15:0] c;
      for (int i = 0; i < 256; i++) begin
         c = 16'(i);
         repeat (8) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
         crc_lut[i] = c;
      end
   end

   initial begin
      #8_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(negedge clock) begin
      if (stall_phase == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_phase = 50;
      end
      stall_phase--;
      case (stall_mode)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= 1'($urandom_range(0, 1));
         default: rsp_if.ready <= (stall_phase % 8 == 0);
      endcase
   end

   always @(posedge clock) begin : monitor
      frame_verdict_type word;
      frame_verdict_type want;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.addr)
               REG_STATION:     cfg_station = csr_if.data[7:0];
               REG_BASE:        cfg_base = csr_if.data;
               REG_STRIDE:      cfg_stride = csr_if.data[15:0];
               REG_FINAL_TOTAL: cfg_final_total = csr_if.data[15:0];
               REG_FINAL_LIMIT: cfg_final_limit = csr_if.data[15:0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            if (judge_byte(req_if.data_byte, req_if.frame_end, word))
               pending_verdicts.push_back(word);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_verdicts.size() == 0) begin
               mismatches++;
               $display("%0t ns: verdict word %0h arrived with none expected", $time,
                        rsp_if.verdict);
            end else begin
               want = pending_verdicts.pop_front();
               verdicts_checked++;
               verdict_tally[want.verdict]++;
               last_seen_verdict = rsp_if.verdict;
               if (rsp_if.verdict !== want.verdict)
                  report_field("verdict", 32'(want.verdict), 32'(rsp_if.verdict));
               if (rsp_if.erase_request !== want.erase_request)
                  report_field("erase_request", 32'(want.erase_request),
                               32'(rsp_if.erase_request));
               if (rsp_if.write_request !== want.write_request)
                  report_field("write_request", 32'(want.write_request),
                               32'(rsp_if.write_request));
               if (rsp_if.write_address !== want.write_address)
                  report_field("write_address", want.write_address, rsp_if.write_address);
               if (rsp_if.payload_length !== want.payload_length)
                  report_field("payload_length", 32'(want.payload_length),
                               32'(rsp_if.payload_length));
               if (rsp_if.session_closed !== want.session_closed)
                  report_field("session_closed", 32'(want.session_closed),
                               32'(rsp_if.session_closed));
            end
         end
      end
   end

   initial begin
      frame_plan_type row;
      int first_random;
      int choice;
      int payload;
      logic [7:0] station;
      logic [15:0] number;
      logic [15:0] total;
      logic [15:0] stride;
      logic [15:0] limit;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data_byte <= 8'h00;
      req_if.frame_end <= 1'b0;
      csr_if.valid <= 1'b0;
      csr_if.addr <= REG_STATION;
      csr_if.data <= '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.preset == PresetHigh)
            apply_settings(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
         else if (row.preset == PresetLow)
            apply_settings(8'h00, 32'h0000_0000, 16'h0000, 16'h0000, 16'hFFFF);
         else if (row.preset == PresetMid)
            apply_settings(StationReset, BaseReset, StrideReset, FinalTotalReset, MidLimit);
         build_frame(int'(row.raw_len), row.station, row.number, row.total, int'(row.payload),
                     row.crc_good);
         send_frame();
         if (row.typed) begin
            req_if.valid <= 1'b0;
            while (pending_verdicts.size() != 0) @(negedge clock);
            if (last_seen_verdict !== row.want)
               report_field("planned verdict", 32'(row.want), 32'(last_seen_verdict));
         end
      end

      first_random = words_sent;
      for (int n = 0; words_sent - first_random < RandomWords; n++) begin
         if (n % 16 == 0) begin
            case ($urandom_range(0, 9))
               0: stride = 16'h0000;
               1: stride = 16'hFFFF;
               default: stride = 16'($urandom);
            endcase
            limit = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
            apply_settings(8'($urandom), $urandom, stride, 16'($urandom), limit);
         end
         choice = $urandom_range(0, 99);
         payload = ($urandom_range(0, 49) == 0) ? $urandom_range(25, 400) : $urandom_range(0, 24);
         station = (choice < 88) ? cfg_station : 8'($urandom);
         case ($urandom_range(0, 9)) inside
            0: number = 16'h0000;
            1: number = FrameNumberEnd;
            [2:3]: number = 16'(payload);
            4: number = 16'($urandom);
            default: number = 16'($urandom_range(1, 40));
         endcase
         total = ($urandom_range(0, 2) == 0) ? cfg_final_total : 16'($urandom);
         build_frame((choice >= 94) ? $urandom_range(1, 12) : 0, station, number, total, payload,
                     $urandom_range(0, 9) != 0);
         send_frame();
      end

      req_if.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("Covered %0d bytes in %0d frames; %0d verdict words compared.", words_sent,
               frames_sent, verdicts_checked);
      $display("Verdicts: start %0d, written %0d, crc %0d, station %0d, length %0d, %s %0d, %s %0d",
               verdict_tally[V_START], verdict_tally[V_WRITTEN], verdict_tally[V_CRC],
               verdict_tally[V_STATION], verdict_tally[V_LENGTH], "overflow",
               verdict_tally[V_OVERFLOW], "end/bad size",
               verdict_tally[V_END] + verdict_tally[V_BADSIZE]);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
